@@ rtl/masked_layer_condition_table_assert.svh @@
// Assertion macros for the masked layer condition table.
`ifndef MASKED_LAYER_CONDITION_TABLE_ASSERT_SVH
`define MASKED_LAYER_CONDITION_TABLE_ASSERT_SVH

// Checked on every clock edge outside reset.
`define MLCT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define MLCT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/mlct_pkg.sv @@
// Shared types, constants and helpers for the masked layer condition table.
package mlct_pkg;

  localparam int STATE_W     = 32;
  localparam int LAYER_W     = 5;
  localparam int SLOT_W      = 3;
  localparam int LAYER_COUNT = 32;

  typedef enum logic [1:0] {
    KIND_UPDATE = 2'd0,
    KIND_ADD    = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [STATE_W-1:0] mask;
    logic [LAYER_W-1:0] layer;
    logic               active;
  } entry_t;

  // Bit of a layer number; layers past the layer count have no bit.
  function automatic logic [STATE_W-1:0] layer_flag(input logic [LAYER_W-1:0] layer);
    logic [STATE_W-1:0] b;
    b = '0;
    if (32'(layer) < 32'(LAYER_COUNT)) begin
      b = {{(STATE_W-1){1'b0}}, 1'b1} << layer;
    end
    return b;
  endfunction

endpackage

@@ rtl/mlct_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module mlct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/masked_layer_condition_table.sv @@
// Top level of the masked layer condition table: sequencer around the rule RAM.
//
// Usage: one input word carries kind, layer_state, rule_mask and rule_layer on
// the in channel (in_valid / in_stall); one result word comes back on the out
// channel (out_valid / out_stall) with result_state, slot and added.
// Items are handled one at a time. Add and remove walk the rule RAM once and
// update walks it twice, one entry a cycle, with the read of the next entry
// overlapping the examination and write-back of the previous one; update then
// writes the winner back in a last step, and an unused kind skips the walk.
// The walk of the RAM sets the pace; in_stall is high while a word is in work
// and drops as the result loads, so a new word is taken only once the last
// one is through.
// A finished result sits in the output register, so the next word is taken
// while the receiver holds out_stall; a new result waits in the last step
// until the output register frees up.
// Reset (rst, synchronous) clears the sequencer and the per-entry valid bits,
// so every slot reads as empty, inactive and zero right away; no clearing
// pass over the RAM is needed.
`include "masked_layer_condition_table_assert.svh"

module masked_layer_condition_table #(
  parameter int ENTRY_COUNT = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [31:0] layer_state,
  input  logic [31:0] rule_mask,
  input  logic [4:0]  rule_layer,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] result_state,
  output logic [2:0]  slot,
  output logic        added
);

  localparam int IDX_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int CNT_W = $clog2(ENTRY_COUNT + 1);
  localparam int ENT_W = $bits(mlct_pkg::entry_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN,
    ST_DONE
  } state_t;

  state_t                          state;
  mlct_pkg::kind_t                 op;
  logic                            pass2;
  logic [CNT_W-1:0]                cnt;
  logic                            ex_vld;
  logic [IDX_W-1:0]                ex_idx;
  logic                            ent_vld;
  logic [mlct_pkg::STATE_W-1:0]    st;
  logic [mlct_pkg::STATE_W-1:0]    req_mask;
  logic [mlct_pkg::LAYER_W-1:0]    req_layer;
  logic [mlct_pkg::STATE_W-1:0]    best_mask;
  logic [mlct_pkg::LAYER_W-1:0]    best_layer;
  logic [IDX_W-1:0]                best_idx;
  logic                            found;
  logic [IDX_W-1:0]                found_idx;
  logic [ENTRY_COUNT-1:0]          vbits;

  logic                            issue;
  logic                            last;
  logic [IDX_W-1:0]                rd_addr;
  logic [ENT_W-1:0]                rdata;
  mlct_pkg::entry_t                ent;
  logic                            contained;
  logic                            wr_en;
  logic [IDX_W-1:0]                wr_addr;
  mlct_pkg::entry_t                wr_ent;
  logic [mlct_pkg::STATE_W-1:0]    st_next;
  logic                            take_best;
  logic                            take_slot;

  mlct_ram #(
    .WIDTH (ENT_W),
    .DEPTH (ENTRY_COUNT)
  ) u_rules (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_ent),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  assign in_stall = (state != ST_IDLE);
  assign issue    = (state == ST_SCAN) && (cnt < CNT_W'(ENTRY_COUNT));
  assign rd_addr  = cnt[IDX_W-1:0];
  assign last     = ex_vld && (ex_idx == IDX_W'(ENTRY_COUNT - 1));

  // An entry that was never written since reset reads as all zero.
  assign ent       = ent_vld ? mlct_pkg::entry_t'(rdata) : '0;
  assign contained = ((ent.mask & st) == ent.mask);

  // Examine the entry read last cycle and decide the write-back.
  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = ex_idx;
    wr_ent    = ent;
    st_next   = st;
    take_best = 1'b0;
    take_slot = 1'b0;
    if (state == ST_SCAN && ex_vld) begin
      unique case (op)
        mlct_pkg::KIND_UPDATE: begin
          if (!pass2) begin
            // Drop a rule whose mask is no longer fully set.
            if (ent.active && !contained) begin
              wr_en      = 1'b1;
              wr_ent.active = 1'b0;
              st_next    = st & ~mlct_pkg::layer_flag(ent.layer);
            end
          end else if (ent.mask != '0 && contained && ent.mask > best_mask) begin
            take_best = 1'b1;
          end
        end
        mlct_pkg::KIND_ADD: begin
          if (!found && ent.mask == '0) begin
            wr_en        = 1'b1;
            wr_ent.mask  = req_mask;
            wr_ent.layer = req_layer;
            take_slot    = 1'b1;
          end
        end
        mlct_pkg::KIND_REMOVE: begin
          if (ent.mask == req_mask && ent.layer == req_layer) begin
            wr_en  = 1'b1;
            wr_ent = '0;
          end
        end
        default: begin
        end
      endcase
    end else if (state == ST_FIN && best_mask != '0) begin
      // Mark the winner active and switch its layer on.
      wr_en         = 1'b1;
      wr_addr       = best_idx;
      wr_ent.mask   = best_mask;
      wr_ent.layer  = best_layer;
      wr_ent.active = 1'b1;
      st_next       = st | mlct_pkg::layer_flag(best_layer);
    end
  end

  // Valid bits: a slot counts as written once the RAM has taken a word for it.
  always_ff @(posedge clk) begin
    if (rst) begin
      vbits <= '0;
    end else if (wr_en) begin
      vbits[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      ex_vld    <= 1'b0;
      cnt       <= '0;
      pass2     <= 1'b0;
      found     <= 1'b0;
      op        <= mlct_pkg::KIND_NONE;
    end else begin
      ent_vld <= vbits[rd_addr];
      ex_vld  <= issue;
      ex_idx  <= rd_addr;
      if (issue) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (take_best) begin
        best_mask  <= ent.mask;
        best_layer <= ent.layer;
        best_idx   <= ex_idx;
      end
      if (take_slot) begin
        found     <= 1'b1;
        found_idx <= ex_idx;
      end
      // Release the output register once the receiver takes the word, unless
      // the next result loads in the same cycle.
      if (out_valid && !out_stall && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            op        <= mlct_pkg::kind_t'(kind);
            st        <= layer_state;
            req_mask  <= rule_mask;
            req_layer <= rule_layer;
            cnt       <= '0;
            pass2     <= 1'b0;
            found     <= 1'b0;
            best_mask <= '0;
            state     <= (mlct_pkg::kind_t'(kind) == mlct_pkg::KIND_NONE) ? ST_DONE : ST_SCAN;
          end
        end
        ST_SCAN: begin
          st <= st_next;
          if (last) begin
            if (op == mlct_pkg::KIND_UPDATE && !pass2) begin
              pass2 <= 1'b1;
              cnt   <= '0;
            end else if (op == mlct_pkg::KIND_UPDATE) begin
              state <= ST_FIN;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_FIN: begin
          st    <= st_next;
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            result_state <= (op == mlct_pkg::KIND_UPDATE) ? st : '0;
            slot         <= (op == mlct_pkg::KIND_ADD && found) ?
                            mlct_pkg::SLOT_W'(found_idx) : '0;
            added        <= (op == mlct_pkg::KIND_ADD) && found;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The examined entry always trails the read pointer by one.
  `MLCT_ASSERT(a_scan_lag, ex_vld |-> (CNT_W'(ex_idx) + CNT_W'(1)) == cnt, "scan pipeline out of step")
  // A result without a slot reports slot zero.
  `MLCT_ASSERT(a_slot_zero, (out_valid && !added) |-> slot == '0, "slot set without an add")
  // Reset leaves the sequencer idle with no result pending.
  `MLCT_ASSERT_ALWAYS(a_reset_idle, $past(rst) |-> (state == ST_IDLE && !out_valid), "not idle after reset")

endmodule
